### sv/single_wire_humidity_sensor_decoder_assert.svh
// assertion macros shared by the humidity sensor decoder modules
// expects aclk and aresetn in the scope of each use
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_DECODER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SWHS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("swhs assertion failed");

`define SWHS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("swhs assertion failed");

`else

`define SWHS_ASSERT_IMP(name, ante, cons)

`define SWHS_ASSERT_NXT(name, ante, cons)

`endif

`endif

### sv/swhs_pkg.sv
// shared types and constants for the single-wire humidity sensor decoder
// no dependencies
`default_nettype none

package swhs_pkg;

    localparam logic [6:0] EDGE_LIMIT     = 7'd85;
    localparam logic [6:0] FIRST_BIT_EDGE = 7'd4;
    localparam logic [5:0] FRAME_BITS     = 6'd40;

    localparam logic [7:0] BIT_THRESHOLD_RESET = 8'd50;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd255;

    // x / 10 == (x * DIV10_MUL) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MUL = 16'hCCCD;

    localparam logic [1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_SHORT    = 2'd1,
        ST_CHECKSUM = 2'd2
    } swhs_status_t;

    typedef struct packed {
        logic [7:0] bit_threshold;
        logic [7:0] timeout_limit;
    } swhs_cfg_t;

    typedef struct packed {
        logic [5:0]  bit_count;
        logic [39:0] bits;
    } swhs_frame_t;

endpackage

`default_nettype wire

### sv/single_wire_humidity_sensor_decoder.sv
// top level of the single-wire humidity sensor frame decoder
// depends on swhs_pkg, swhs_tracker and swhs_format
`default_nettype none

// Takes one line sample beat per cycle and returns one result beat when a frame ends
// (timeout or edge limit). A beat is accepted every cycle while the result register is
// empty or being taken; the pipeline is input register, tracker state, result register,
// through which the frame-ending sample beat's result passes in that order. The whole
// pipeline stalls only while a result waits in the output register and m_tready is low.
// Configuration writes are always accepted and should be made while no frame is open.

module single_wire_humidity_sensor_decoder import swhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // start_req, line_level, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // frame_status, bits_received, humidity_tenths,
                                   // temperature_tenths, humidity_whole,
                                   // temperature_whole, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    swhs_cfg_t   cfg_reg;
    logic        advance;
    logic        in_accept;
    logic        ev_valid;
    swhs_frame_t ev_frame;

    logic               res_valid;
    logic [1:0]         frame_status;
    logic [5:0]         bits_received;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
    logic [12:0]        humidity_whole;
    logic signed [12:0] temperature_whole;

    assign advance   = !res_valid || m_tready;
    assign s_tready  = advance;
    assign in_accept = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_threshold <= BIT_THRESHOLD_RESET;
            cfg_reg.timeout_limit <= TIMEOUT_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BIT_THRESHOLD: cfg_reg.bit_threshold <= cfg_data;
                CFG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    swhs_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_start  (s_tdata[0]),
        .in_level  (s_tdata[1]),
        .advance   (advance),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev_frame  (ev_frame)
    );

    swhs_format u_format (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .advance            (advance),
        .ev_valid           (ev_valid),
        .ev_frame           (ev_frame),
        .res_valid          (res_valid),
        .frame_status       (frame_status),
        .bits_received      (bits_received),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .humidity_whole     (humidity_whole),
        .temperature_whole  (temperature_whole)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, temperature_whole, humidity_whole, temperature_tenths,
                       humidity_tenths, bits_received, frame_status};

endmodule

`default_nettype wire

### sv/swhs_tracker.sv
// input register and frame tracking: runs, edges, bit capture, frame end
// depends on swhs_pkg and the assertion macro header
`default_nettype none
`include "single_wire_humidity_sensor_decoder_assert.svh"

module swhs_tracker import swhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic        in_start,
    input  logic        in_level,
    input  logic        advance,
    input  swhs_cfg_t   cfg,
    output logic        ev_valid,
    output swhs_frame_t ev_frame
);

    logic        in_valid_reg;
    logic        in_start_reg;
    logic        in_level_reg;

    logic        in_frame_reg, in_frame_next;
    logic        last_level_reg, last_level_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic [6:0]  edge_index_reg, edge_index_next;
    logic [5:0]  bit_count_reg, bit_count_next;
    logic [39:0] frame_bits_reg, frame_bits_next;

    logic        ev_valid_reg, ev_valid_next;
    swhs_frame_t ev_frame_reg;

    logic        step;
    logic [7:0]  run_inc;
    logic [6:0]  edge_inc;

    assign step     = in_valid_reg && advance;
    assign run_inc  = run_count_reg + 8'd1;
    assign edge_inc = edge_index_reg + 7'd1;

    always_comb begin
        in_frame_next   = in_frame_reg;
        last_level_next = last_level_reg;
        run_count_next  = run_count_reg;
        edge_index_next = edge_index_reg;
        bit_count_next  = bit_count_reg;
        frame_bits_next = frame_bits_reg;
        ev_valid_next   = 1'b0;
        if (in_start_reg) begin
            in_frame_next   = 1'b1;
            last_level_next = 1'b1;
            run_count_next  = 8'd0;
            edge_index_next = 7'd0;
            bit_count_next  = 6'd0;
            frame_bits_next = 40'd0;
        end else if (in_frame_reg) begin
            if (in_level_reg == last_level_reg) begin
                run_count_next = run_inc;
                if (run_inc >= cfg.timeout_limit) begin
                    ev_valid_next = 1'b1;
                    in_frame_next = 1'b0;
                end
            end else begin
                if (edge_index_reg >= FIRST_BIT_EDGE && !edge_index_reg[0] &&
                    bit_count_reg < FRAME_BITS) begin
                    frame_bits_next = {frame_bits_reg[38:0],
                                       run_count_reg > cfg.bit_threshold};
                    bit_count_next  = bit_count_reg + 6'd1;
                end
                last_level_next = in_level_reg;
                run_count_next  = 8'd0;
                edge_index_next = edge_inc;
                if (edge_inc >= EDGE_LIMIT) begin
                    ev_valid_next = 1'b1;
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            last_level_reg <= 1'b1;
            run_count_reg  <= 8'd0;
            edge_index_reg <= 7'd0;
            bit_count_reg  <= 6'd0;
            frame_bits_reg <= 40'd0;
            ev_valid_reg   <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= in_accept;
            ev_valid_reg <= step && ev_valid_next;
            if (step) begin
                in_frame_reg   <= in_frame_next;
                last_level_reg <= last_level_next;
                run_count_reg  <= run_count_next;
                edge_index_reg <= edge_index_next;
                bit_count_reg  <= bit_count_next;
                frame_bits_reg <= frame_bits_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_start_reg <= in_start;
            in_level_reg <= in_level;
        end
        if (advance) begin
            ev_frame_reg.bit_count <= bit_count_next;
            ev_frame_reg.bits      <= frame_bits_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev_frame = ev_frame_reg;

    `SWHS_ASSERT_IMP(a_bit_count_bound, 1'b1, bit_count_reg <= FRAME_BITS)
    `SWHS_ASSERT_NXT(a_start_opens, step && in_start_reg, in_frame_reg && bit_count_reg == 6'd0)
    `SWHS_ASSERT_NXT(a_end_closes, step && ev_valid_next, !in_frame_reg && ev_valid_reg)
    `SWHS_ASSERT_IMP(a_event_in_frame, step && ev_valid_next, in_frame_reg && !in_start_reg)

endmodule

`default_nettype wire

### sv/swhs_format.sv
// frame result decode: checksum, status, tenths and whole-unit values
// depends on swhs_pkg and the assertion macro header
`default_nettype none
`include "single_wire_humidity_sensor_decoder_assert.svh"

module swhs_format import swhs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               ev_valid,
    input  swhs_frame_t        ev_frame,
    output logic               res_valid,
    output logic [1:0]         frame_status,
    output logic [5:0]         bits_received,
    output logic [15:0]        humidity_tenths,
    output logic signed [15:0] temperature_tenths,
    output logic [12:0]        humidity_whole,
    output logic signed [12:0] temperature_whole
);

    logic                res_valid_reg;
    logic [1:0]          status_reg, status_next;
    logic [5:0]          count_reg;
    logic [15:0]         hum_reg, hum_next;
    logic signed [15:0]  tmp_reg, tmp_next;
    logic [12:0]         hum_whole_reg, hum_whole_next;
    logic signed [12:0]  tmp_whole_reg, tmp_whole_next;

    logic [7:0]  b0, b1, b2, b3, b4, sum;
    logic [15:0] hum;
    logic [14:0] mag;
    logic [31:0] hum_prod, mag_prod;
    logic [11:0] mag_whole;

    always_comb begin
        b0        = ev_frame.bits[39:32];
        b1        = ev_frame.bits[31:24];
        b2        = ev_frame.bits[23:16];
        b3        = ev_frame.bits[15:8];
        b4        = ev_frame.bits[7:0];
        sum       = b0 + b1 + b2 + b3;
        hum       = {b0, b1};
        mag       = {b2[6:0], b3};
        hum_prod  = {16'd0, hum} * {16'd0, DIV10_MUL};
        mag_prod  = {17'd0, mag} * {16'd0, DIV10_MUL};
        mag_whole = mag_prod[30:19];

        status_next    = ST_GOOD;
        hum_next       = 16'd0;
        tmp_next       = 16'sd0;
        hum_whole_next = 13'd0;
        tmp_whole_next = 13'sd0;
        if (ev_frame.bit_count < FRAME_BITS) begin
            status_next = ST_SHORT;
        end else begin
            if (sum != b4) begin
                status_next = ST_CHECKSUM;
            end
            hum_next       = hum;
            hum_whole_next = hum_prod[31:19];
            if (b2[7]) begin
                tmp_next       = 16'd0 - {1'b0, mag};
                tmp_whole_next = 13'd0 - {1'b0, mag_whole};
            end else begin
                tmp_next       = {1'b0, mag};
                tmp_whole_next = {1'b0, mag_whole};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= ev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg    <= status_next;
            count_reg     <= ev_frame.bit_count;
            hum_reg       <= hum_next;
            tmp_reg       <= tmp_next;
            hum_whole_reg <= hum_whole_next;
            tmp_whole_reg <= tmp_whole_next;
        end
    end

    assign res_valid          = res_valid_reg;
    assign frame_status       = status_reg;
    assign bits_received      = count_reg;
    assign humidity_tenths    = hum_reg;
    assign temperature_tenths = tmp_reg;
    assign humidity_whole     = hum_whole_reg;
    assign temperature_whole  = tmp_whole_reg;

    `SWHS_ASSERT_IMP(a_good_is_full, res_valid_reg && status_reg != ST_SHORT, count_reg == FRAME_BITS)
    `SWHS_ASSERT_IMP(a_short_is_zero, res_valid_reg && status_reg == ST_SHORT, hum_reg == 16'd0 && tmp_reg == 16'sd0)
    `SWHS_ASSERT_IMP(a_status_code, res_valid_reg, status_reg == ST_GOOD || status_reg == ST_SHORT || status_reg == ST_CHECKSUM)
    `SWHS_ASSERT_IMP(a_whole_sign, res_valid_reg, tmp_reg[15] == tmp_whole_reg[12] || tmp_whole_reg == 13'sd0)

endmodule

`default_nettype wire

### verif/swhs_frame_checker.sv
// frame checker for the single-wire humidity sensor decoder: watches the sample,
// result and register channels, predicts each frame result and compares it
// depends on swhs_pkg
`default_nettype none

module swhs_frame_checker import swhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        swhs_status_t status;
        logic [5:0]   bits;
        logic [15:0]  hum;
        logic [15:0]  temp;
        logic [12:0]  hum_whole;
        logic [12:0]  temp_whole;
    } frame_result_t;

    swhs_cfg_t     cfg;
    logic          in_frame;
    logic          last_level;
    logic [7:0]    run_len;
    logic [6:0]    edge_idx;
    swhs_frame_t   frame;
    frame_result_t expected_frames[$];
    int            mismatches = 0;

    task automatic close_frame();
        frame_result_t r;
        logic [7:0]    b0, b1, b2, b3, b4;
        logic [14:0]   mag;
        logic [12:0]   mag_whole;
        r = '0;
        if (frame.bit_count < FRAME_BITS) begin
            r.status = ST_SHORT;
        end else begin
            {b0, b1, b2, b3, b4} = frame.bits;
            r.status = (8'(b0 + b1 + b2 + b3) != b4) ? ST_CHECKSUM : ST_GOOD;
            r.hum = {b0, b1};
            r.hum_whole = 13'(r.hum / 16'd10);
            mag = {b2[6:0], b3};
            mag_whole = 13'(mag / 15'd10);
            if (b2[7]) begin
                r.temp = -16'(mag);
                r.temp_whole = -mag_whole;
            end else begin
                r.temp = 16'(mag);
                r.temp_whole = mag_whole;
            end
        end
        r.bits = frame.bit_count;
        expected_frames.push_back(r);
        in_frame = 1'b0;
    endtask

    task automatic decode_sample(input logic start, input logic level);
        if (start) begin
            in_frame = 1'b1;
            last_level = 1'b1;
            run_len = '0;
            edge_idx = '0;
            frame = '0;
        end else if (in_frame) begin
            if (level == last_level) begin
                run_len = run_len + 8'd1;
                if (run_len >= cfg.timeout_limit) close_frame();
            end else begin
                if (edge_idx >= FIRST_BIT_EDGE && !edge_idx[0] && frame.bit_count < FRAME_BITS) begin
                    frame.bits = {frame.bits[38:0], run_len > cfg.bit_threshold};
                    frame.bit_count = frame.bit_count + 6'd1;
                end
                last_level = level;
                run_len = '0;
                edge_idx = edge_idx + 7'd1;
                if (edge_idx >= EDGE_LIMIT) close_frame();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [71:0] beat);
        frame_result_t want;
        if (expected_frames.size() == 0) begin
            $error("result beat 0x%0h with no frame result expected", beat);
            mismatches++;
        end else begin
            want = expected_frames.pop_front();
            check_field("frame_status", 16'(want.status), 16'(beat[1:0]));
            check_field("bits_received", 16'(want.bits), 16'(beat[7:2]));
            check_field("humidity_tenths", want.hum, beat[23:8]);
            check_field("temperature_tenths", want.temp, beat[39:24]);
            check_field("humidity_whole", 16'(want.hum_whole), 16'(beat[52:40]));
            check_field("temperature_whole", 16'(want.temp_whole), 16'(beat[65:53]));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.bit_threshold = BIT_THRESHOLD_RESET;
            cfg.timeout_limit = TIMEOUT_LIMIT_RESET;
            in_frame = 1'b0;
            last_level = 1'b1;
            run_len = '0;
            edge_idx = '0;
            frame = '0;
            expected_frames.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BIT_THRESHOLD: cfg.bit_threshold = cfg_data;
                    CFG_TIMEOUT_LIMIT: cfg.timeout_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_sample(s_tdata[0], s_tdata[1]);
        end
        pending_frames <= expected_frames.size();
        fail_count <= mismatches;
    end

endmodule

`default_nettype wire

### verif/testbench.sv
// top of the humidity sensor decoder testbench: clock, reset, sample stimulus,
// register writes and result back-pressure; checking is done in swhs_frame_checker
// depends on swhs_pkg, swhs_frame_checker and the decoder rtl
`default_nettype none

module testbench import swhs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef enum int {TAIL_TIMEOUT, TAIL_EDGES, TAIL_ABANDON} frame_tail_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BIT_THRESHOLD;
    logic [7:0]  cfg_data = '0;

    int fail_count;
    int pending_frames;
    int thr_cur = 50;
    int tmo_cur = 255;
    int items_sent = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int stuck_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    always #5 aclk = ~aclk;

    single_wire_humidity_sensor_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swhs_frame_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_frames (pending_frames)
    );

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) results_seen <= results_seen + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        bit hold_taken;
        hold_taken = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(input logic start, input logic level);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, level, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_run(input logic level, input int len);
        repeat (len) send_sample(1'b0, level);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_cfg(input int thr, input int tmo);
        write_reg(CFG_BIT_THRESHOLD, 8'(thr));
        write_reg(CFG_TIMEOUT_LIMIT, 8'(tmo));
        cfg_valid <= 1'b0;
        thr_cur = thr;
        tmo_cur = tmo;
    endtask

    // no sample in flight and every frame result taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_frames != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int zero_len();
        return $urandom_range(1, (thr_cur + 1 < tmo_cur) ? thr_cur + 1 : tmo_cur);
    endfunction

    function automatic int one_len();
        if (thr_cur + 2 > tmo_cur) return tmo_cur;
        return $urandom_range(thr_cur + 2, (thr_cur + 5 < tmo_cur) ? thr_cur + 5 : tmo_cur);
    endfunction

    // sensor frame: response pulses, then a low and a coded high per bit
    task automatic send_frame(input int nbits, input frame_tail_t tail);
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [39:0] word;
        int          sel;
        sel = (frames_sent < 5) ? frames_sent : $urandom_range(0, 9);
        {b0, b1, b2, b3} = $urandom;
        case (sel)
            0: {b0, b1, b2, b3} = 32'h0000_8000;   // negative zero
            1: {b0, b1, b2, b3} = 32'hFFFF_FFFF;
            2: {b0, b1, b2, b3} = 32'h0000_0000;
            3: {b0, b1, b2, b3} = 32'hFFFF_7FFF;
            default: ;
        endcase
        b4 = b0 + b1 + b2 + b3;
        if (sel == 4 || $urandom_range(0, 3) == 0) b4 = b4 ^ 8'($urandom_range(1, 255));
        word = {b0, b1, b2, b3, b4};
        frames_sent++;
        send_sample(1'b1, 1'($urandom_range(0, 1)));
        send_run(1'b1, $urandom_range(0, (tmo_cur - 1 < 3) ? tmo_cur - 1 : 3));
        send_run(1'b0, zero_len());
        send_run(1'b1, zero_len());
        for (int i = 0; i < nbits; i++) begin
            send_run(1'b0, zero_len());
            send_run(1'b1, (i < 40 && word[39 - i]) ? one_len() : zero_len());
        end
        case (tail)
            TAIL_TIMEOUT: begin
                send_run(1'b0, zero_len());
                send_run(1'b1, tmo_cur + 1);
            end
            TAIL_EDGES: begin
                send_run(1'b0, zero_len());
                send_run(1'b1, zero_len());
                send_run(1'b0, 1);
            end
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int phase;
        int thr;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle samples, start tick, instant timeout, restart inside a frame
        write_cfg(0, 1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        wait_drained();

        // a result every other beat while the result side holds off
        hold_req <= 1'b1;
        repeat (40) begin
            send_sample(1'b1, 1'($urandom_range(0, 1)));
            send_sample(1'b0, 1'b1);
        end
        wait_drained();

        phase = 0;
        while (phase < 3 || items_sent < 720) begin
            if (phase == 1) begin
                // widest settings: longest run just under the limit, then close on edges
                write_cfg(254, 255);
                send_sample(1'b1, 1'b1);
                send_run(1'b0, 1);
                send_run(1'b1, 1);
                send_run(1'b0, 1);
                send_run(1'b1, 255);
                send_run(1'b0, 1);
                for (int i = 0; i < 80; i++) send_sample(1'b0, !i[0]);
            end else begin
                thr = $urandom_range(0, 2);
                write_cfg(thr, $urandom_range(thr + 1, thr + 8));
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                            send_frame(40, $urandom_range(0, 1) ? TAIL_EDGES : TAIL_TIMEOUT);
                        end
                        5: send_frame(41, $urandom_range(0, 1) ? TAIL_EDGES : TAIL_TIMEOUT);
                        6: send_frame($urandom_range(0, 39), TAIL_TIMEOUT);
                        7: send_frame($urandom_range(0, 39), TAIL_ABANDON);
                        8: begin
                            repeat ($urandom_range(5, 30)) begin
                                send_sample($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
                            end
                        end
                        default: begin
                            send_run(1'b1, tmo_cur + 2);
                            repeat ($urandom_range(3, 12)) begin
                                send_sample(1'b0, 1'($urandom_range(0, 1)));
                            end
                        end
                    endcase
                end
                // steady line closes any open frame before the next register write
                send_run(1'b1, tmo_cur + 2);
            end
            wait_drained();
            phase++;
        end

        // back to back on both sides
        quiet <= 1'b1;
        write_cfg(0, 2);
        send_frame(40, TAIL_EDGES);
        wait_drained();

        repeat (12) @(posedge aclk);
        $display("covered %0d sample beats and %0d frame results", items_sent, results_seen);
        $display("frames with short runs, checksum errors, extra edges, restarts and stalls");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
